// File: rtl/slvl_pkg.sv
`timescale 1ns / 1ps
// Package for the stack of variable-length lists.
// Holds the sizes and widths shared by the channel interfaces and the top level.
package slvl_pkg;

   localparam int WORD_W       = 32;
   localparam int ELEM_DEPTH   = 1024;
   localparam int ELEM_AW      = $clog2(ELEM_DEPTH);
   localparam int WP_W         = ELEM_AW + 1;
   localparam int MAX_FRAMES   = 256;
   localparam int FRAME_AW     = $clog2(MAX_FRAMES);
   localparam int FC_W         = FRAME_AW + 1;
   localparam int MAX_LIST_LEN = 64;
   localparam int LEN_W        = $clog2(MAX_LIST_LEN + 1);

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

endpackage

// File: rtl/slvl_req_if.sv
`timescale 1ns / 1ps
// Request channel interface: valid, ready and one push or pop transaction.
// Depends on slvl_pkg.
interface slvl_req_if;
   import slvl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [WORD_W-1:0] value;
   logic                     last;

   modport source (output valid, output mode, output value, output last, input ready);
   modport sink   (input valid, input mode, input value, input last, output ready);

endinterface

// File: rtl/slvl_rsp_if.sv
`timescale 1ns / 1ps
// Response channel interface: valid, ready and one popped word per transaction.
// Depends on slvl_pkg.
interface slvl_rsp_if;
   import slvl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] word;
   logic                     final_res;
   logic                     empty_res;

   modport source (output valid, output word, output final_res, output empty_res,
                   input ready);
   modport sink   (input valid, input word, input final_res, input empty_res,
                   output ready);

endinterface

// File: rtl/stack_of_variable_length_lists.sv
`timescale 1ns / 1ps
// Top level of the stack of variable-length lists.
// Depends on slvl_pkg, slvl_req_if and slvl_rsp_if.

// A push transaction stores one word per cycle into the element memory while no
// pop is in progress; the word flagged last closes the list and makes it the new
// top of the stack. A pop transaction first reads the top list's start from the
// frame memory, then streams the list from the element memory at one word per
// cycle while the output queue has room, first word to last, with final_res on
// the last one; a pop of an empty stack returns a single word of zero with
// final_res and empty_res set. The request side is ready again once the pop's
// last read is issued or its empty word is queued. Results pass through a
// two-entry output queue; a stalled response side holds back the element memory
// reads and the empty word, and so the request side. Lists that exceed 64
// words, the 1024-word element memory or 256 stacked lists are dropped whole.
// Both memories need no initialization after reset.
module stack_of_variable_length_lists (
   input logic        clock,
   input logic        reset,
   slvl_req_if.sink   req_ch,
   slvl_rsp_if.source rsp_ch
);
   import slvl_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FRAME  = 2'd1;
   localparam logic [1:0] ST_STREAM = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   logic [WORD_W-1:0]   elem_mem [ELEM_DEPTH];
   logic [ELEM_AW-1:0]  frame_mem [MAX_FRAMES];

   logic [1:0]          state_ff, state_in;
   logic [FC_W-1:0]     fc_ff, fc_in;
   logic [WP_W-1:0]     wp_ff, wp_in;
   logic [LEN_W-1:0]    ol_ff, ol_in;
   logic                drop_ff, drop_in;
   logic [WP_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [WP_W-1:0]     strm_end_ff, strm_end_in;
   logic                rd_pend_ff;
   logic                rd_fin_ff;
   logic [WORD_W-1:0]   elem_rdata_ff;
   logic [ELEM_AW-1:0]  frame_rdata_ff;

   logic [WORD_W-1:0]   fifo_word_ff [2];
   logic                fifo_fin_ff [2];
   logic                fifo_emp_ff [2];
   logic                fifo_wr_ff, fifo_rd_ff;
   logic [1:0]          fifo_cnt_ff, fifo_cnt_in;

   logic                req_take, rsp_take;
   logic                push, pop;
   logic                full, elem_we, frame_we, frame_re;
   logic [WP_W-1:0]     wp_ab, open_start;
   logic [FC_W-1:0]     fc_dec;
   logic [2:0]          occ;
   logic                room, issue, issue_last, empty_enq, enq;
   logic [WORD_W-1:0]   enq_word;
   logic                enq_fin, enq_emp;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign push         = req_take && (req_ch.mode == MODE_PUSH);
   assign pop          = req_take && (req_ch.mode == MODE_POP);

   assign rsp_ch.valid     = (fifo_cnt_ff != 2'd0);
   assign rsp_ch.word      = fifo_word_ff[fifo_rd_ff];
   assign rsp_ch.final_res = fifo_fin_ff[fifo_rd_ff];
   assign rsp_ch.empty_res = fifo_emp_ff[fifo_rd_ff];
   assign rsp_take         = rsp_ch.valid && rsp_ch.ready;

   assign full = (ol_ff >= LEN_W'(MAX_LIST_LEN)) || (wp_ff >= WP_W'(ELEM_DEPTH)) ||
                 (fc_ff >= FC_W'(MAX_FRAMES));
   assign wp_ab  = wp_ff - WP_W'(ol_ff);
   assign fc_dec = fc_ff - FC_W'(1);

   assign occ  = {1'b0, fifo_cnt_ff} + {2'b00, rd_pend_ff};
   assign room = occ < (3'd2 + {2'b00, rsp_take});

   assign issue      = (state_ff == ST_STREAM) && room;
   assign issue_last = (rd_addr_ff + WP_W'(1)) == strm_end_ff;
   assign empty_enq  = (state_ff == ST_EMPTY) && !rd_pend_ff && room;
   assign enq        = rd_pend_ff || empty_enq;
   assign enq_word   = rd_pend_ff ? elem_rdata_ff : '0;
   assign enq_fin    = rd_pend_ff ? rd_fin_ff : 1'b1;
   assign enq_emp    = !rd_pend_ff;

   assign frame_re = pop && (fc_ff != '0);

   always_comb begin
      state_in    = state_ff;
      fc_in       = fc_ff;
      wp_in       = wp_ff;
      ol_in       = ol_ff;
      drop_in     = drop_ff;
      rd_addr_in  = rd_addr_ff;
      strm_end_in = strm_end_ff;
      elem_we     = 1'b0;
      frame_we    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (push) begin
               if (!drop_ff) begin
                  if (full) begin
                     wp_in   = wp_ab;
                     ol_in   = '0;
                     drop_in = 1'b1;
                  end else begin
                     elem_we = 1'b1;
                     wp_in   = wp_ff + WP_W'(1);
                     ol_in   = ol_ff + LEN_W'(1);
                  end
               end
               if (req_ch.last) begin
                  if (!drop_in && (ol_in != '0) && (fc_ff < FC_W'(MAX_FRAMES))) begin
                     frame_we = 1'b1;
                     fc_in    = fc_ff + FC_W'(1);
                  end
                  ol_in   = '0;
                  drop_in = 1'b0;
               end
            end else if (pop) begin
               wp_in   = wp_ab;
               ol_in   = '0;
               drop_in = 1'b0;
               if (fc_ff == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  fc_in    = fc_dec;
                  state_in = ST_FRAME;
               end
            end
         end
         ST_FRAME: begin
            rd_addr_in  = {1'b0, frame_rdata_ff};
            strm_end_in = wp_ff;
            wp_in       = {1'b0, frame_rdata_ff};
            state_in    = ST_STREAM;
         end
         ST_STREAM: begin
            if (issue) begin
               rd_addr_in = rd_addr_ff + WP_W'(1);
               if (issue_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (empty_enq) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign open_start = wp_in - WP_W'(ol_ff + LEN_W'(1));

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[wp_ff[ELEM_AW-1:0]] <= req_ch.value;
      end
      if (issue) begin
         elem_rdata_ff <= elem_mem[rd_addr_ff[ELEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[fc_ff[FRAME_AW-1:0]] <= open_start[ELEM_AW-1:0];
      end
      if (frame_re) begin
         frame_rdata_ff <= frame_mem[fc_dec[FRAME_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         fifo_word_ff[fifo_wr_ff] <= enq_word;
         fifo_fin_ff[fifo_wr_ff]  <= enq_fin;
         fifo_emp_ff[fifo_wr_ff]  <= enq_emp;
      end
      rd_fin_ff   <= issue_last;
      rd_addr_ff  <= rd_addr_in;
      strm_end_ff <= strm_end_in;
   end

   assign fifo_cnt_in = fifo_cnt_ff + {1'b0, enq} - {1'b0, rsp_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fc_ff       <= '0;
         wp_ff       <= '0;
         ol_ff       <= '0;
         drop_ff     <= 1'b0;
         rd_pend_ff  <= 1'b0;
         fifo_wr_ff  <= 1'b0;
         fifo_rd_ff  <= 1'b0;
         fifo_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fc_ff       <= fc_in;
         wp_ff       <= wp_in;
         ol_ff       <= ol_in;
         drop_ff     <= drop_in;
         rd_pend_ff  <= issue;
         fifo_cnt_ff <= fifo_cnt_in;
         if (enq) begin
            fifo_wr_ff <= !fifo_wr_ff;
         end
         if (rsp_take) begin
            fifo_rd_ff <= !fifo_rd_ff;
         end
      end
   end

   // The output queue never holds more than its two entries.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff != 2'd3)
      else $error("output queue over its depth");

   // A read is issued only inside the list being popped.
   a_read_in_list: assert property (@(posedge clock) disable iff (reset)
      issue |-> (rd_addr_ff < strm_end_ff))
      else $error("element read outside the popped list");

   // A read that is not the list's last keeps the stream going.
   a_stream_cont: assert property (@(posedge clock) disable iff (reset)
      (issue && !issue_last) |=> (state_ff == ST_STREAM))
      else $error("stream ended before the last word");

   // The open list fits below wp; wp and the frame count stay within their depths.
   a_open_within: assert property (@(posedge clock) disable iff (reset)
      (WP_W'(ol_ff) <= wp_ff) && (wp_ff <= WP_W'(ELEM_DEPTH)) &&
      (fc_ff <= FC_W'(MAX_FRAMES)))
      else $error("stack pointers out of range");

endmodule
